// File: rtl/core/cnm_pkg.sv
// cnm_pkg: shared types and constants for count_non_multiples_in_range
// no dependencies
`timescale 1ns / 1ps
package cnm_pkg;
  localparam int BoundW = 32;
  localparam int WideW  = 64;
  typedef logic [WideW-1:0] wide_t;
  typedef logic [BoundW-1:0] bound_t;

  // divider request / response between sequencer and shared divider
  typedef struct packed {
    logic  start;
    wide_t num;
    wide_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    wide_t quo;
    wide_t rem;
  } div_rsp_t;
endpackage

// File: rtl/core/cnm_div.sv
// cnm_div: shared restoring divider, one quotient bit per cycle
// depends on cnm_pkg
`timescale 1ns / 1ps
module cnm_div (
  input  logic             clk,
  input  logic             rst,
  input  cnm_pkg::div_req_t req,
  output cnm_pkg::div_rsp_t rsp
);
  import cnm_pkg::*;

  logic          busy;
  logic          done;
  logic [6:0]    cnt;
  wide_t         quo;
  wide_t         rem;
  wide_t         den;
  logic [WideW:0] trial;

  // shift in next numerator bit and test subtract
  assign trial = {rem, quo[WideW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'(WideW);
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (trial[WideW]) begin
          rem <= {rem[WideW-2:0], quo[WideW-1]};
          quo <= {quo[WideW-2:0], 1'b0};
        end else begin
          rem <= trial[WideW-1:0];
          quo <= {quo[WideW-2:0], 1'b1};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // result visible while idle after completion
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;
endmodule

// File: rtl/core/count_non_multiples_in_range.sv
`timescale 1ns / 1ps
// count_non_multiples_in_range: top level, sequencer around one shared divider
// depends on cnm_pkg, cnm_div
//
// Takes one request on s_axis (range_low, range_high, first_divisor,
// divisor_step) and returns the count of integers in the range divisible by
// none of the divisors a, a+d, ... on m_axis.
// The block works on one request at a time: s_axis_tready is low from
// acceptance until the result has been taken on m_axis.
// Work: for each bound (high, then low-1) and each nonempty divisor subset the
// running lcm is built with Euclid's gcd; every gcd step, the lcm quotient and
// the final bound/lcm all run on the one restoring divider, with a 32x32
// multiply between divisions. Latency is data dependent.
// The result waits in the output register while the receiver stalls.
// Reset (rst, synchronous) returns the sequencer to idle and drops any
// pending result.
module count_non_multiples_in_range #(
  parameter int NUM_DIVISORS = 5
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // range_low[31:0], range_high[63:32], first_divisor[95:64], divisor_step[127:96]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // count[31:0]
  output logic [31:0]  m_axis_tdata
);
  import cnm_pkg::*;

  localparam int MaskW = NUM_DIVISORS;
  localparam int IdxW  = (NUM_DIVISORS > 1) ? $clog2(NUM_DIVISORS) : 1;

  // state codes
  localparam logic [3:0] S_IDLE = 4'd0, S_BOUND = 4'd1, S_MASK = 4'd2,
    S_ELEM = 4'd3, S_GCD = 4'd4, S_GCDW = 4'd5, S_LCMW = 4'd6, S_MUL = 4'd7,
    S_CNTW = 4'd8, S_NEXTM = 4'd9, S_OUT = 4'd10, S_QDIV = 4'd11;

  logic [3:0]       state;
  bound_t           low, high, a, d;
  wide_t            bound;
  logic             second;
  logic [MaskW-1:0] mask;
  logic [IdxW-1:0]  idx;
  logic             par;
  wide_t            acc, b, gx, gy, divv;
  logic [WideW+1:0] hit;
  logic [WideW+1:0] res_hi;
  logic [31:0]      result;
  div_req_t         dreq;
  div_rsp_t         drsp;

  cnm_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // current divisor a + idx*d (fits 35 bits)
  always_comb begin
    divv = {32'd0, a} + (64'(idx) * {32'd0, d});
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dreq.start <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            low  <= (s_axis_tdata[31:0] == 32'd0) ? 32'd1 : s_axis_tdata[31:0];
            high <= s_axis_tdata[63:32];
            a    <= s_axis_tdata[95:64];
            d    <= s_axis_tdata[127:96];
            state <= S_BOUND;
          end
        end
        // choose bound, or finish
        S_BOUND: begin
          if (high < low) begin
            result <= 32'd0;
            state  <= S_OUT;
          end else begin
            bound  <= {32'd0, high};
            second <= 1'b0;
            hit    <= '0;
            mask   <= MaskW'(1);
            state  <= S_MASK;
          end
        end
        // start a subset
        S_MASK: begin
          if (bound == '0) begin
            state <= S_NEXTM;
            mask  <= '0;
          end else begin
            acc <= 64'd1;
            par <= 1'b0;
            idx <= '0;
            state <= S_ELEM;
          end
        end
        // walk subset members
        S_ELEM: begin
          if (!mask[idx]) begin
            if (32'(idx) == NUM_DIVISORS - 1) begin
              dreq.num   <= bound;
              dreq.den   <= acc;
              dreq.start <= 1'b1;
              state      <= S_CNTW;
            end else idx <= idx + IdxW'(1);
          end else begin
            par <= ~par;
            if (divv == '0 || divv > bound) state <= S_NEXTM;
            else begin
              b  <= divv;
              gx <= acc;
              gy <= divv;
              state <= S_GCD;
            end
          end
        end
        // euclid step
        S_GCD: begin
          if (gy == '0) begin
            dreq.num   <= acc;
            dreq.den   <= gx;
            dreq.start <= 1'b1;
            state      <= S_LCMW;
          end else begin
            dreq.num   <= gx;
            dreq.den   <= gy;
            dreq.start <= 1'b1;
            state      <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (drsp.done) begin
            gx <= gy;
            gy <= drsp.rem;
            state <= S_GCD;
          end
        end
        S_LCMW: begin
          if (drsp.done) begin
            acc   <= drsp.quo;
            state <= S_MUL;
          end
        end
        // acc/g and b are both at most bound < 2^32, product fits 64 bits
        S_MUL: begin
          acc   <= {32'd0, acc[31:0]} * {32'd0, b[31:0]};
          state <= S_QDIV;
        end
        S_QDIV: begin
          if (acc > bound) state <= S_NEXTM;
          else if (32'(idx) == NUM_DIVISORS - 1) begin
            dreq.num   <= bound;
            dreq.den   <= acc;
            dreq.start <= 1'b1;
            state      <= S_CNTW;
          end else begin
            idx   <= idx + IdxW'(1);
            state <= S_ELEM;
          end
        end
        S_CNTW: begin
          if (drsp.done) begin
            hit   <= par ? hit + {2'd0, drsp.quo} : hit - {2'd0, drsp.quo};
            state <= S_NEXTM;
          end
        end
        // next subset, next bound, or finish
        S_NEXTM: begin
          if (mask == '1 || mask == '0) begin
            if (!second) begin
              res_hi <= {2'd0, bound} - hit;
              bound  <= {32'd0, low - 32'd1};
              second <= 1'b1;
              hit    <= '0;
              mask   <= MaskW'(1);
              state  <= S_MASK;
            end else begin
              result <= 32'(res_hi - ({2'd0, bound} - hit));
              state  <= S_OUT;
            end
          end else begin
            mask  <= mask + MaskW'(1);
            state <= S_MASK;
          end
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for count_non_multiples_in_range, one request at a time
// depends on cnm_pkg and the count_non_multiples_in_range rtl
// predicts each count by inclusion-exclusion over the divisor subsets, checks in order

class count_scoreboard;
  localparam int NDIV = 5;
  longint unsigned expected_counts[$];
  int mismatches;

  function longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // integers in 1..bound that no divisor divides
  function longint unsigned free_below(longint unsigned bound, longint unsigned dv[NDIV]);
    longint unsigned hit, acc;
    int size;
    bit keep;
    hit = 0;
    if (bound == 0) return 0;
    for (int mask = 1; mask < (1 << NDIV); mask++) begin
      acc = 1;
      size = 0;
      keep = 1;
      for (int i = 0; i < NDIV; i++) begin
        if (keep && mask[i]) begin
          size++;
          if (dv[i] == 0 || dv[i] > bound) keep = 0;
          else begin
            acc = (acc / gcd64(acc, dv[i])) * dv[i];
            if (acc > bound) keep = 0;
          end
        end
      end
      if (keep) begin
        if (size % 2 == 1) hit += bound / acc;
        else hit -= bound / acc;
      end
    end
    return bound - hit;
  endfunction

  function void note_request(bit [31:0] lo, bit [31:0] hi, bit [31:0] a, bit [31:0] d);
    longint unsigned dv[NDIV];
    longint unsigned low_b, res;
    for (int k = 0; k < NDIV; k++) dv[k] = longint'(a) + longint'(k) * longint'(d);
    low_b = (lo == 0) ? 1 : lo;
    res = 0;
    if (longint'(hi) >= low_b) res = free_below(hi, dv) - free_below(low_b - 1, dv);
    expected_counts.push_back(res & 64'hFFFF_FFFF);
  endfunction

  function void check_result(bit [31:0] actual);
    longint unsigned want;
    if (expected_counts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: count=%0d", actual);
      return;
    end
    want = expected_counts.pop_front();
    if (want[31:0] != actual) begin
      mismatches++;
      if (mismatches <= 10) $display("count mismatch: expected %0d, got %0d", want, actual);
    end
  endfunction
endclass

module tb_top;
  import cnm_pkg::*;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // range_low, range_high, first_divisor, divisor_step
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // count
  logic [31:0]  m_axis_tdata;

  count_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  hold_left;

  count_non_multiples_in_range dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (1000) #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver side ready, with a long hold-off on request while a result waits
  initial begin
    m_axis_tready = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) hold_left = 3000;
      if (hold_left > 0) begin
        if (m_axis_tvalid) hold_left--;
        m_axis_tready <= 1'b0;
        if (hold_left == 0) hold_req = 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic send_request(bit [31:0] lo, bit [31:0] hi, bit [31:0] a, bit [31:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, a, hi, lo};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(lo, hi, a, d);
  endtask

  // random request, mostly small sizes so runs stay short
  task automatic send_random();
    bit [31:0] lo, hi, a, d;
    int kind;
    kind = $urandom_range(99);
    if (kind < 70) begin
      lo = $urandom_range(2000, 1);
      hi = lo + $urandom_range(3000);
      a  = $urandom_range(40, 1);
      d  = $urandom_range(25);
    end else if (kind < 92) begin
      lo = $urandom_range(32'h000F_FFFF, 1);
      hi = lo + $urandom_range(32'h00FF_FFFF);
      a  = $urandom_range(5000, 1);
      d  = $urandom_range(3000);
    end else begin
      lo = $urandom;
      hi = $urandom;
      if (lo == 0) lo = 1;
      if ($urandom_range(3) != 0 && hi < lo) hi = lo;
      a = $urandom;
      if (a == 0) a = 1;
      d = $urandom;
    end
    send_request(lo, hi, a, d);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 19;
    recv_idle_pct = 60;
    hold_req = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, step zero, empty range, low of zero, wide lcm
    send_request(1, 1, 1, 0);
    send_request(1, 100, 2, 1);
    send_request(1, 100, 2, 0);
    send_request(10, 5, 3, 1);
    send_request(0, 50, 3, 2);
    send_request(1, 32'hFFFF_FFFF, 1, 0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(1, 32'hFFFF_FFFF, 2, 1);
    send_request(32'h8000_0000, 32'hFFFF_FFFF, 65521, 65519);
    send_request(1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(1000, 1000000, 7, 6);
    send_request(1, 1000, 1001, 5);
    send_request(12, 12, 2, 1);
    send_request(13, 13, 2, 1);
    send_request(1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 3, 32'h5555_5555);

    for (int n = 0; n < 150; n++) begin
      if (n == 50) begin
        send_idle_pct = 60;
        recv_idle_pct = 19;
      end
      if (n == 100) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1;
      end
      send_random();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_counts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_counts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
